[rtl/core/kmp_pattern_matcher_macros.svh]
// ----------------------------------------------------------------------------
// KMP pattern matcher assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef KMP_PATTERN_MATCHER_MACROS_SVH
`define KMP_PATTERN_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset.
`define KMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every clock edge, reset included.
`define KMP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// KMP matcher package
// Shared widths, command codes and the link-walk status type.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int PATTERN_MAX_DEF    = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int DATA_W    = 8;
    localparam int START_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int LEN_OUT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // Status of one failure-link step
    typedef struct packed {
        logic done;   // walk ends with this step
        logic eq;     // stored byte equals the current byte
    } kmp_step_t;

endpackage

[rtl/core/kmp_in_if.sv]
// ----------------------------------------------------------------------------
// KMP matcher input channel
// Valid/ready channel carrying one pattern or text byte per word.
// ----------------------------------------------------------------------------
interface kmp_in_if import kmp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DATA_W-1:0] data;
    logic              first;

    modport source (output valid, output cmd, output data, output first, input ready);
    modport sink   (input valid, input cmd, input data, input first, output ready);

endinterface

[rtl/core/kmp_out_if.sv]
// ----------------------------------------------------------------------------
// KMP matcher result channel
// Valid/ready channel carrying one result word per input word.
// ----------------------------------------------------------------------------
interface kmp_out_if import kmp_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 match_found;
    logic [START_W-1:0]   match_start;
    logic [COUNT_W-1:0]   match_count;
    logic [LEN_OUT_W-1:0] pattern_length;
    logic                 pattern_overflow;

    modport source (
        output valid, output match_found, output match_start, output match_count,
        output pattern_length, output pattern_overflow, input ready
    );
    modport sink (
        input valid, input match_found, input match_start, input match_count,
        input pattern_length, input pattern_overflow, output ready
    );

endinterface

[rtl/core/kmp_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// KMP pattern matcher
// Streaming Knuth-Morris-Pratt matcher with online failure-table build.
// ----------------------------------------------------------------------------
// Takes one word at a time and returns exactly one result word for each. A
// pattern word (cmd 0) stores a byte and extends the failure table; a text word
// (cmd 1) advances the match and flags each completed occurrence, overlapping
// ones included, with its start position and a saturating count. first starts
// a new pattern or a new text. A word is accepted in S_IDLE, follows failure
// links in S_WALK, fetches the link of the whole pattern in S_TAIL when it
// completes an occurrence, and leaves in S_EMIT, which holds while the
// previous result still sits unread in the result register; the first byte of
// a pattern, a dropped pattern byte or a text byte against an empty pattern
// goes straight to S_EMIT. The walk uses the single compare-and-follow unit,
// which reads the pattern and failure memories through one registered read port.
// ready is high only between words; a finished result waits in its own
// register, so the next word is accepted while the previous result is unread.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher import kmp_pkg::*; #(
    parameter int PATTERN_MAX    = PATTERN_MAX_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int LW = $clog2(PATTERN_MAX + 1),
    localparam int IW = $clog2(PATTERN_MAX)
) (
    input  logic      clk,
    input  logic      rst_n,
    kmp_in_if.sink    item,
    kmp_out_if.source result
);

    logic              pat_we;
    logic [IW-1:0]     pat_waddr;
    logic [DATA_W-1:0] pat_wdata;
    logic              fail_we;
    logic [IW-1:0]     fail_waddr;
    logic [IW-1:0]     fail_wdata;
    logic [LW-1:0]     rd_addr;
    logic [DATA_W-1:0] pat_rd;
    logic [IW-1:0]     fail_rd;
    logic [LW-1:0]     step_k;
    logic [DATA_W-1:0] step_data;
    kmp_step_t         step_flags;
    logic [LW-1:0]     step_k_new;

    kmp_ctrl #(
        .PATTERN_MAX    (PATTERN_MAX),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .pat_we     (pat_we),
        .pat_waddr  (pat_waddr),
        .pat_wdata  (pat_wdata),
        .fail_we    (fail_we),
        .fail_waddr (fail_waddr),
        .fail_wdata (fail_wdata),
        .rd_addr    (rd_addr),
        .fail_rd    (fail_rd),
        .step_k     (step_k),
        .step_data  (step_data),
        .step_flags (step_flags),
        .step_k_new (step_k_new)
    );

    kmp_mem #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_mem (
        .clk        (clk),
        .pat_we     (pat_we),
        .pat_waddr  (pat_waddr),
        .pat_wdata  (pat_wdata),
        .fail_we    (fail_we),
        .fail_waddr (fail_waddr),
        .fail_wdata (fail_wdata),
        .rd_addr    (rd_addr),
        .pat_rd     (pat_rd),
        .fail_rd    (fail_rd)
    );

    kmp_step #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_step (
        .k       (step_k),
        .data    (step_data),
        .pat_rd  (pat_rd),
        .fail_rd (fail_rd),
        .flags   (step_flags),
        .k_new   (step_k_new)
    );

endmodule

[rtl/core/kmp_mem.sv]
// ----------------------------------------------------------------------------
// KMP pattern and failure-link memories
// One write port each, one shared read address, registered read data.
// failure_mem[a] holds the border length of the first a+1 pattern bytes.
// ----------------------------------------------------------------------------
module kmp_mem import kmp_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    localparam int LW = $clog2(PATTERN_MAX + 1),
    localparam int IW = $clog2(PATTERN_MAX)
) (
    input  logic              clk,
    input  logic              pat_we,
    input  logic [IW-1:0]     pat_waddr,
    input  logic [DATA_W-1:0] pat_wdata,
    input  logic              fail_we,
    input  logic [IW-1:0]     fail_waddr,
    input  logic [IW-1:0]     fail_wdata,
    input  logic [LW-1:0]     rd_addr,
    output logic [DATA_W-1:0] pat_rd,
    output logic [IW-1:0]     fail_rd
);

    logic [DATA_W-1:0] pattern_mem [PATTERN_MAX];
    logic [IW-1:0]     failure_mem [PATTERN_MAX];

    logic [IW-1:0] pat_raddr;
    logic [IW-1:0] fail_raddr;

    // link of length k lives one entry down; length zero has no entry
    assign pat_raddr  = IW'(rd_addr);
    assign fail_raddr = (rd_addr == '0) ? '0 : IW'(rd_addr - 1'b1);

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_mem[pat_waddr] <= pat_wdata;
        end
        if (fail_we)
        begin
            failure_mem[fail_waddr] <= fail_wdata;
        end
        pat_rd  <= pattern_mem[pat_raddr];
        fail_rd <= failure_mem[fail_raddr];
    end

endmodule

[rtl/core/kmp_step.sv]
// ----------------------------------------------------------------------------
// KMP link-walk step unit
// Compares the stored byte at length k with the current byte and either
// extends the match, stops at zero, or follows the failure link.
// ----------------------------------------------------------------------------
module kmp_step import kmp_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    localparam int LW = $clog2(PATTERN_MAX + 1),
    localparam int IW = $clog2(PATTERN_MAX)
) (
    input  logic [LW-1:0]     k,
    input  logic [DATA_W-1:0] data,
    input  logic [DATA_W-1:0] pat_rd,
    input  logic [IW-1:0]     fail_rd,
    output kmp_step_t         flags,
    output logic [LW-1:0]     k_new
);

    always_comb
    begin
        flags.eq = (pat_rd == data);
        if (flags.eq)
        begin
            flags.done = 1'b1;
            k_new      = k + 1'b1;
        end
        else if (k == '0)
        begin
            // link of length zero is minus one; the increment brings it back
            flags.done = 1'b1;
            k_new      = '0;
        end
        else
        begin
            flags.done = 1'b0;
            k_new      = LW'(fail_rd);
        end
    end

endmodule

[rtl/core/kmp_ctrl.sv]
// ----------------------------------------------------------------------------
// KMP matcher sequencer
// Accepts one word at a time, drives the link walk over the memories,
// keeps length, border, match, position and count state and the result word.
// ----------------------------------------------------------------------------
`include "kmp_pattern_matcher_macros.svh"

module kmp_ctrl import kmp_pkg::*; #(
    parameter int PATTERN_MAX    = PATTERN_MAX_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int LW = $clog2(PATTERN_MAX + 1),
    localparam int IW = $clog2(PATTERN_MAX),
    localparam int PW = POSITION_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    kmp_in_if.sink            item,
    kmp_out_if.source         result,
    output logic              pat_we,
    output logic [IW-1:0]     pat_waddr,
    output logic [DATA_W-1:0] pat_wdata,
    output logic              fail_we,
    output logic [IW-1:0]     fail_waddr,
    output logic [IW-1:0]     fail_wdata,
    output logic [LW-1:0]     rd_addr,
    input  logic [IW-1:0]     fail_rd,
    output logic [LW-1:0]     step_k,
    output logic [DATA_W-1:0] step_data,
    input  kmp_step_t         step_flags,
    input  logic [LW-1:0]     step_k_new
);

    localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_MAX);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_TAIL, S_EMIT} state_t;

    state_t               state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [DATA_W-1:0]    byte_reg, byte_next;
    logic [LW-1:0]        k_reg, k_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        border_reg, border_next;
    logic [LW-1:0]        matched_reg, matched_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        item_pos_reg, item_pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [COUNT_W-1:0]   count_o_reg, count_o_next;
    logic [LEN_OUT_W-1:0] len_o_reg, len_o_next;
    logic                 ovf_o_reg, ovf_o_next;

    logic          accept;
    logic [PW-1:0] start_val;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign start_val  = item_pos_reg + PW'(1) - PW'(len_reg);

    assign step_k    = k_reg;
    assign step_data = byte_reg;
    assign rd_addr   = k_next;

    assign result.valid            = out_valid_reg;
    assign result.match_found      = found_reg;
    assign result.match_start      = start_reg;
    assign result.match_count      = count_o_reg;
    assign result.pattern_length   = len_o_reg;
    assign result.pattern_overflow = ovf_o_reg;

    always_comb
    begin
        logic [LW-1:0] eff_len;
        logic [LW-1:0] eff_match;
        logic [PW-1:0] eff_pos;

        eff_len        = item.first ? '0 : len_reg;
        eff_match      = item.first ? '0 : matched_reg;
        eff_pos        = item.first ? '0 : pos_reg;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        border_next    = border_reg;
        matched_next   = matched_reg;
        pos_next       = pos_reg;
        item_pos_next  = item_pos_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        count_o_next   = count_o_reg;
        len_o_next     = len_o_reg;
        ovf_o_next     = ovf_o_reg;

        pat_we     = 1'b0;
        pat_waddr  = IW'(eff_len);
        pat_wdata  = item.data;
        fail_we    = 1'b0;
        fail_waddr = IW'(len_reg);
        fail_wdata = IW'(step_k_new);

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = item.cmd;
                    byte_next = item.data;
                    hit_next  = 1'b0;
                    if (item.cmd == CMD_PATTERN)
                    begin
                        if (item.first)
                        begin
                            ovf_next     = 1'b0;
                            matched_next = '0;
                        end
                        len_next = eff_len;
                        if (eff_len == LEN_FULL)
                        begin
                            // store full: drop the byte
                            ovf_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            pat_we = 1'b1;
                            if (eff_len == '0)
                            begin
                                fail_we     = 1'b1;
                                fail_waddr  = '0;
                                fail_wdata  = '0;
                                border_next = '0;
                                len_next    = LW'(1);
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                k_next     = border_reg;
                                state_next = S_WALK;
                            end
                        end
                    end
                    else
                    begin
                        item_pos_next = eff_pos;
                        pos_next      = eff_pos + 1'b1;
                        matched_next  = eff_match;
                        if (item.first)
                        begin
                            count_next = '0;
                        end
                        if (len_reg == '0)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            k_next     = (eff_match >= len_reg) ? '0 : eff_match;
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                if (!step_flags.done)
                begin
                    k_next = step_k_new;
                end
                else if (cmd_reg == CMD_PATTERN)
                begin
                    fail_we     = 1'b1;
                    border_next = step_k_new;
                    len_next    = len_reg + 1'b1;
                    state_next  = S_EMIT;
                end
                else if (step_k_new == len_reg)
                begin
                    // full occurrence: fetch the link of the whole pattern
                    hit_next = 1'b1;
                    k_next   = len_reg;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_TAIL;
                end
                else
                begin
                    matched_next = step_k_new;
                    state_next   = S_EMIT;
                end
            end

            S_TAIL:
            begin
                matched_next = LW'(fail_rd);
                state_next   = S_EMIT;
            end

            S_EMIT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    start_next     = hit_reg ? START_W'(start_val) : '0;
                    count_o_next   = count_reg;
                    len_o_next     = LEN_OUT_W'(len_reg);
                    ovf_o_next     = ovf_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_PATTERN;
            byte_reg      <= '0;
            k_reg         <= '0;
            len_reg       <= '0;
            border_reg    <= '0;
            matched_reg   <= '0;
            pos_reg       <= '0;
            item_pos_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            count_o_reg   <= '0;
            len_o_reg     <= '0;
            ovf_o_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            byte_reg      <= byte_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            border_reg    <= border_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            item_pos_reg  <= item_pos_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            start_reg     <= start_next;
            count_o_reg   <= count_o_next;
            len_o_reg     <= len_o_next;
            ovf_o_reg     <= ovf_o_next;
        end
    end

    `KMP_ASSERT(a_walk_in_range, clk, rst_n, state_reg == S_WALK |-> k_reg < len_reg, "walk index not below stored length")
    `KMP_ASSERT(a_match_bounded, clk, rst_n, state_reg == S_IDLE |-> matched_reg <= len_reg, "match state exceeds pattern length")
    `KMP_ASSERT(a_ovf_when_full, clk, rst_n, ovf_reg |-> len_reg == LEN_FULL, "overflow set while store not full")
    `KMP_ASSERT(a_count_monotonic, clk, rst_n, state_reg != S_IDLE |=> count_reg >= $past(count_reg), "match count dropped mid-word")
    `KMP_ASSERT_NR(a_no_result_in_reset, clk, !rst_n |-> !result.valid, "result valid during reset")

endmodule
